@@ design/lobm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the order book matcher.
// No dependencies; used by every module of the block.
package lobm_pkg;

	localparam int BOOK_DEPTH = 256;
	localparam int IDX_W      = $clog2(BOOK_DEPTH);

	typedef enum logic [2:0] {
		STAT_NEW       = 3'd0,
		STAT_PARTIAL   = 3'd1,
		STAT_FILLED    = 3'd2,
		STAT_CANCELLED = 3'd3,
		STAT_REJECTED  = 3'd4,
		STAT_NOT_FOUND = 3'd5
	} stat_t;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic FUNC_NEW    = 1'b0;
	localparam logic FUNC_CANCEL = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic SIDE_SELL   = 1'b1;

	typedef enum logic [1:0] {
		W_LOAD,
		W_REM,
		W_CLR
	} wop_t;

	typedef enum logic [1:0] {
		P_MATCH,
		P_REST,
		P_CXL
	} purp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEWRPT,
		S_REJ,
		S_CHECK,
		S_SCAN,
		S_RESOLVE,
		S_FINAL
	} state_t;

	// Search word that travels down the row of entries.
	typedef struct packed {
		logic             tok;
		logic             bfound;
		logic [IDX_W-1:0] bidx;
		logic [19:0]      bprice;
		logic [31:0]      barr;
		logic [31:0]      brem;
		logic [31:0]      boid;
		logic [31:0]      btid;
		logic             cfound;
		logic [IDX_W-1:0] cidx;
		logic [31:0]      crem;
		logic             ffound;
		logic [IDX_W-1:0] fidx;
	} cand_t;

	typedef struct packed {
		logic        opp;
		logic [31:0] oid;
	} query_t;

	typedef struct packed {
		logic             en;
		wop_t             op;
		logic [IDX_W-1:0] idx;
		logic             side;
		logic [19:0]      price;
		logic [31:0]      rem;
		logic [31:0]      arr;
		logic [31:0]      oid;
		logic [31:0]      tid;
	} wcmd_t;

endpackage

@@ design/lobm_cell.sv @@
`timescale 1ns / 1ps
// One book entry of the matcher row, with its stage of the search word.
// Depends on lobm_pkg.
module lobm_cell import lobm_pkg::*; #(
	parameter logic [IDX_W-1:0] IDX = '0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  query_t q,
	input  wcmd_t  w,
	input  cand_t  cand_in,
	output cand_t  cand_out
);

	logic        valid_q;
	logic        side_q;
	logic [19:0] price_q;
	logic [31:0] rem_q;
	logic [31:0] arr_q;
	logic [31:0] oid_q;
	logic [31:0] tid_q;
	cand_t       cand_q;
	cand_t       nxt;
	logic        better;
	logic        hit;

	always_comb begin
		better = 1'b0;
		if (valid_q && side_q == q.opp) begin
			if (!cand_in.bfound)
				better = 1'b1;
			else if (q.opp == SIDE_SELL ? (price_q < cand_in.bprice) : (price_q > cand_in.bprice))
				better = 1'b1;
			else if (price_q == cand_in.bprice && arr_q < cand_in.barr)
				better = 1'b1;
		end
		nxt = cand_in;
		if (better) begin
			nxt.bfound = 1'b1;
			nxt.bidx   = IDX;
			nxt.bprice = price_q;
			nxt.barr   = arr_q;
			nxt.brem   = rem_q;
			nxt.boid   = oid_q;
			nxt.btid   = tid_q;
		end
		if (!cand_in.cfound && valid_q && oid_q == q.oid) begin
			nxt.cfound = 1'b1;
			nxt.cidx   = IDX;
			nxt.crem   = rem_q;
		end
		if (!cand_in.ffound && !valid_q) begin
			nxt.ffound = 1'b1;
			nxt.fidx   = IDX;
		end
	end

	assign hit = w.en && w.idx == IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= '0;
		end else begin
			cand_q <= nxt;
			if (hit) begin
				unique case (w.op)
					W_LOAD: valid_q <= 1'b1;
					W_REM:  valid_q <= (w.rem != 32'd0);
					W_CLR:  valid_q <= 1'b0;
					default: valid_q <= valid_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && w.op == W_LOAD) begin
			side_q  <= w.side;
			price_q <= w.price;
			arr_q   <= w.arr;
			oid_q   <= w.oid;
			tid_q   <= w.tid;
		end
		if (hit && (w.op == W_LOAD || w.op == W_REM))
			rem_q <= w.rem;
	end

	assign cand_out = cand_q;

endmodule

@@ design/lobm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the matcher: takes orders, starts searches of the entry row,
// forms trade and status words and holds the output register. Uses lobm_pkg.
module lobm_ctrl import lobm_pkg::*; #(
	parameter int MAX_FILLS = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        side,
	input  logic [19:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] order_id,
	input  logic [31:0] trader_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] trade_id,
	output logic [31:0] buy_order_id,
	output logic [31:0] sell_order_id,
	output logic [31:0] buy_trader_id,
	output logic [31:0] sell_trader_id,
	output logic [19:0] exec_price,
	output logic [31:0] exec_quantity,
	output logic [31:0] report_order_id,
	output logic [2:0]  order_status,
	output logic [31:0] remaining_quantity,
	output logic        last,
	output query_t      q,
	output wcmd_t       w,
	output cand_t       seed,
	input  cand_t       res
);

	localparam int FW = $clog2(MAX_FILLS + 1);

	state_t      state_q, state_d;
	purp_t       purp_q, purp_d;
	logic        side_q;
	logic [19:0] price_q;
	logic [31:0] qty_q, oid_q, tid_q, rem_q;
	logic [FW-1:0] fills_q;
	logic [31:0] trade_no_q, arrival_q;
	cand_t       res_q;
	logic        out_free, emit, scan_start, trade, load;
	logic [31:0] m, rrem;
	logic        cross_ok;

	logic        o_kind, o_last;
	logic [31:0] o_tid, o_boid, o_soid, o_btid, o_stid, o_qty, o_roid, o_rem;
	logic [19:0] o_price;
	stat_t       o_stat;

	logic        ov_q, k_q, l_q;
	logic [31:0] t_q, bo_q, so_q, bt_q, st_q, eq_q, ro_q, rq_q;
	logic [19:0] ep_q;
	stat_t       os_q;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign q.opp    = ~side_q;
	assign q.oid    = oid_q;

	assign m    = (rem_q < res_q.brem) ? rem_q : res_q.brem;
	assign rrem = res_q.brem - m;
	assign cross_ok = res_q.bfound && (price_q == 20'd0 ||
		(side_q == SIDE_BUY ? res_q.bprice <= price_q : res_q.bprice >= price_q));

	always_comb begin
		state_d = state_q;
		purp_d  = purp_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				state_d = (func == FUNC_CANCEL) ? S_CHECK : S_NEWRPT;
				purp_d  = (func == FUNC_CANCEL) ? P_CXL : P_MATCH;
			end
			S_NEWRPT: if (out_free) state_d = (qty_q == 32'd0) ? S_REJ : S_CHECK;
			S_REJ:    if (out_free) state_d = S_IDLE;
			S_CHECK: begin
				if (purp_q == P_CXL)
					state_d = S_SCAN;
				else if (rem_q != 32'd0 && fills_q < FW'(MAX_FILLS)) begin
					state_d = S_SCAN;
					purp_d  = P_MATCH;
				end else if (rem_q == 32'd0 || price_q == 20'd0)
					state_d = S_FINAL;
				else begin
					state_d = S_SCAN;
					purp_d  = P_REST;
				end
			end
			S_SCAN: if (res.tok) state_d = S_RESOLVE;
			S_RESOLVE: begin
				if (purp_q == P_CXL) begin
					if (out_free) state_d = S_IDLE;
				end else if (purp_q == P_MATCH && cross_ok) begin
					if (out_free) state_d = S_CHECK;
				end else
					state_d = S_FINAL;
			end
			S_FINAL: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0; scan_start = 1'b0; trade = 1'b0; load = 1'b0;
		o_kind = KIND_STATUS; o_last = 1'b0; o_stat = STAT_NEW;
		o_tid = '0; o_boid = '0; o_soid = '0; o_btid = '0; o_stid = '0;
		o_qty = '0; o_price = '0; o_roid = oid_q; o_rem = '0;
		w = '0;
		w.op = W_CLR;
		unique case (state_q)
			S_NEWRPT: begin
				emit  = out_free;
				o_rem = qty_q;
			end
			S_REJ: begin
				emit   = out_free;
				o_stat = STAT_REJECTED;
				o_last = 1'b1;
			end
			S_CHECK: scan_start = (purp_q == P_CXL) ||
				(rem_q != 32'd0 && (fills_q < FW'(MAX_FILLS) || price_q != 20'd0));
			S_RESOLVE: begin
				if (purp_q == P_CXL) begin
					emit   = out_free;
					o_last = 1'b1;
					o_stat = res_q.cfound ? STAT_CANCELLED : STAT_NOT_FOUND;
					o_rem  = res_q.cfound ? res_q.crem : 32'd0;
					w.en   = out_free && res_q.cfound;
					w.idx  = res_q.cidx;
				end else if (purp_q == P_MATCH && cross_ok) begin
					emit    = out_free;
					trade   = out_free;
					o_kind  = KIND_TRADE;
					o_tid   = trade_no_q;
					o_boid  = (side_q == SIDE_BUY) ? oid_q : res_q.boid;
					o_soid  = (side_q == SIDE_BUY) ? res_q.boid : oid_q;
					o_btid  = (side_q == SIDE_BUY) ? tid_q : res_q.btid;
					o_stid  = (side_q == SIDE_BUY) ? res_q.btid : tid_q;
					o_price = res_q.bprice;
					o_qty   = m;
					o_roid  = res_q.boid;
					o_stat  = (rrem == 32'd0) ? STAT_FILLED : STAT_PARTIAL;
					o_rem   = rrem;
					w.en    = out_free;
					w.op    = W_REM;
					w.idx   = res_q.bidx;
					w.rem   = rrem;
				end
			end
			S_FINAL: begin
				emit   = out_free;
				o_last = 1'b1;
				o_rem  = rem_q;
				if (rem_q == 32'd0)
					o_stat = STAT_FILLED;
				else if (price_q == 20'd0 || !res_q.ffound)
					o_stat = STAT_CANCELLED;
				else begin
					o_stat  = (rem_q == qty_q) ? STAT_NEW : STAT_PARTIAL;
					load    = out_free;
					w.en    = out_free;
					w.op    = W_LOAD;
					w.idx   = res_q.fidx;
					w.side  = side_q;
					w.price = price_q;
					w.rem   = rem_q;
					w.arr   = arrival_q;
					w.oid   = oid_q;
					w.tid   = tid_q;
				end
			end
			default: ;
		endcase
		seed     = '0;
		seed.tok = scan_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			purp_q     <= P_MATCH;
			fills_q    <= '0;
			trade_no_q <= 32'd1;
			arrival_q  <= 32'd0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			purp_q  <= purp_d;
			if (in_valid && in_ready)
				fills_q <= '0;
			else if (trade)
				fills_q <= fills_q + 1'b1;
			if (trade)
				trade_no_q <= trade_no_q + 32'd1;
			if (load)
				arrival_q <= arrival_q + 32'd1;
			if (emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_q  <= side;
			price_q <= price;
			qty_q   <= quantity;
			oid_q   <= order_id;
			tid_q   <= trader_id;
			rem_q   <= quantity;
		end else if (trade)
			rem_q <= rem_q - m;
		if (state_q == S_SCAN && res.tok)
			res_q <= res;
		if (emit) begin
			k_q  <= o_kind;  t_q  <= o_tid;  bo_q <= o_boid; so_q <= o_soid;
			bt_q <= o_btid;  st_q <= o_stid; ep_q <= o_price; eq_q <= o_qty;
			ro_q <= o_roid;  os_q <= o_stat; rq_q <= o_rem;  l_q  <= o_last;
		end
	end

	assign out_valid          = ov_q;
	assign kind               = k_q;
	assign trade_id           = t_q;
	assign buy_order_id       = bo_q;
	assign sell_order_id      = so_q;
	assign buy_trader_id      = bt_q;
	assign sell_trader_id     = st_q;
	assign exec_price         = ep_q;
	assign exec_quantity      = eq_q;
	assign report_order_id    = ro_q;
	assign order_status       = os_q;
	assign remaining_quantity = rq_q;
	assign last               = l_q;

endmodule

@@ design/limit_order_book_matcher_top.sv @@
`timescale 1ns / 1ps
// Price-time priority matcher: each of the BOOK_DEPTH book entries lives in a cell of a row,
// and every search walks a word down the row, one cell per clock. A search runs from its
// start at the first cell to its result at the end of the row, and is then resolved. A new order
// with F fills whose last search finds nothing to cross takes F + 1 searches; a fully filled
// order needs one search fewer, and a limit order that rests after the fill cap one extra
// search. A cancel takes one search. The sequencer waits while a result word is held by the
// receiver. One order is processed at a time; results leave
// through a one-word output register. Depends on lobm_pkg, lobm_cell and lobm_ctrl.
module limit_order_book_matcher_top import lobm_pkg::*; #(
	parameter int MAX_FILLS  = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        side,
	input  logic [19:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] order_id,
	input  logic [31:0] trader_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] trade_id,
	output logic [31:0] buy_order_id,
	output logic [31:0] sell_order_id,
	output logic [31:0] buy_trader_id,
	output logic [31:0] sell_trader_id,
	output logic [19:0] exec_price,
	output logic [31:0] exec_quantity,
	output logic [31:0] report_order_id,
	output logic [2:0]  order_status,
	output logic [31:0] remaining_quantity,
	output logic        last
);

	query_t q;
	wcmd_t  w;
	cand_t  chain [BOOK_DEPTH+1];

	lobm_ctrl #(.MAX_FILLS(MAX_FILLS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .side(side), .price(price), .quantity(quantity),
		.order_id(order_id), .trader_id(trader_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .trade_id(trade_id),
		.buy_order_id(buy_order_id), .sell_order_id(sell_order_id),
		.buy_trader_id(buy_trader_id), .sell_trader_id(sell_trader_id),
		.exec_price(exec_price), .exec_quantity(exec_quantity),
		.report_order_id(report_order_id), .order_status(order_status),
		.remaining_quantity(remaining_quantity), .last(last),
		.q(q), .w(w), .seed(chain[0]), .res(chain[BOOK_DEPTH])
	);

	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		lobm_cell #(.IDX(IDX_W'(i))) u_cell (
			.clk(clk), .arst_n(arst_n), .q(q), .w(w),
			.cand_in(chain[i]), .cand_out(chain[i+1])
		);
	end

endmodule

@@ design/lobm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the matcher, bound to the top level.
// Depends on lobm_pkg and limit_order_book_matcher_top.
module lobm_checker import lobm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [31:0] trade_id,
	input logic [31:0] exec_quantity,
	input logic [31:0] remaining_quantity,
	input logic        last
);

	// A held word must stay valid and keep its kind and remaining quantity.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remaining_quantity) && $stable(kind))
		else $error("output word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("took a new word while busy");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("idle with an unfinished result pending");

	a_trade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TRADE |-> exec_quantity != 32'd0 && !last)
		else $error("bad trade word");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> trade_id == 32'd0 && exec_quantity == 32'd0)
		else $error("status word carries trade data");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
	.trade_id(trade_id), .exec_quantity(exec_quantity),
	.remaining_quantity(remaining_quantity), .last(last)
);
